/* src/mclp_pkg.sv */
package mclp_pkg;

  localparam int unsigned NUM_KW      = 6;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_EMPTY   = 3'd1;
  localparam logic [2:0] ST_UNKNOWN = 3'd2;
  localparam logic [2:0] ST_MISSING = 3'd3;
  localparam logic [2:0] ST_INVALID = 3'd4;

  localparam logic [2:0] KIND_NONE    = 3'd0;
  localparam logic [2:0] KIND_PING    = 3'd1;
  localparam logic [2:0] KIND_STATUS  = 3'd2;
  localparam logic [2:0] KIND_MOVE    = 3'd3;
  localparam logic [2:0] KIND_STOP    = 3'd4;
  localparam logic [2:0] KIND_ESTOP   = 3'd5;
  localparam logic [2:0] KIND_FLT_CLR = 3'd6;
  localparam logic [2:0] KIND_UNKNOWN = 3'd7;

  localparam logic [1:0] ARG_X = 2'd0;
  localparam logic [1:0] ARG_Y = 2'd1;
  localparam logic [1:0] ARG_F = 2'd2;

  localparam logic [22:0] POS_LIMIT  = 23'd2147483;
  localparam logic [22:0] FEED_LIMIT = 23'd4294967;
  localparam logic [9:0]  MM_SCALE   = 10'd1000;
  localparam logic [6:0]  TOKEN_MAX  = 7'd127;

  typedef struct packed {
    logic [7:0] ch;
    logic [3:0] dval;
    logic       nul;
    logic       delim;
    logic       digit;
    logic       last;
  } entry_t;

  function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [3:0] pos);
    logic [95:0] t;
    int          idx;
    unique case (k)
      3'd0:    t = "PING        ";
      3'd1:    t = "STATUS      ";
      3'd2:    t = "MOVE        ";
      3'd3:    t = "STOP        ";
      3'd4:    t = "ESTOP       ";
      3'd5:    t = {"CLEAR_", "FAULT "};
      default: t = '0;
    endcase
    idx = 95 - 8 * int'(pos);
    return t[idx -: 8];
  endfunction

  function automatic logic [3:0] kw_len(input logic [2:0] k);
    unique case (k)
      3'd0:    return 4'd4;
      3'd1:    return 4'd6;
      3'd2:    return 4'd4;
      3'd3:    return 4'd4;
      3'd4:    return 4'd5;
      3'd5:    return 4'd11;
      default: return 4'd0;
    endcase
  endfunction

  function automatic logic [2:0] kw_kind(input logic [2:0] k);
    unique case (k)
      3'd0:    return KIND_PING;
      3'd1:    return KIND_STATUS;
      3'd2:    return KIND_MOVE;
      3'd3:    return KIND_STOP;
      3'd4:    return KIND_ESTOP;
      3'd5:    return KIND_FLT_CLR;
      default: return KIND_NONE;
    endcase
  endfunction

endpackage

/* src/motion_command_line_parser.sv */
// Parses ASCII motion command lines one byte per cycle unless a stalled
// result fills the two-entry request queue that parts the byte classifier
// from the parser; the rate is set by the parser's per-byte state update.
// The byte flagged line_end produces one result in an output register, and
// it waits in the queue only while a previous result is still stalled.
module motion_command_line_parser #(
  parameter int unsigned LINE_BUFFER_BYTES = 96
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         char_byte_i,
  input  logic               line_end_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         parse_status_o,
  output logic [2:0]         command_kind_o,
  output logic signed [31:0] x_position_o,
  output logic signed [31:0] y_position_o,
  output logic [31:0]        feedrate_o
);

  logic             push, pop, full, q_valid;
  mclp_pkg::entry_t f_entry, q_entry;
  logic [31:0]      xo, yo;

  mclp_front u_front (
    .in_valid_i (in_valid_i),
    .char_byte_i(char_byte_i),
    .line_end_i (line_end_i),
    .full_i     (full),
    .in_stall_o (in_stall_o),
    .push_o     (push),
    .entry_o    (f_entry)
  );

  mclp_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .entry_i(f_entry),
    .pop_i  (pop),
    .full_o (full),
    .valid_o(q_valid),
    .entry_o(q_entry)
  );

  mclp_back #(.LINE_BUFFER_BYTES(LINE_BUFFER_BYTES)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_entry_i     (q_entry),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .parse_status_o(parse_status_o),
    .command_kind_o(command_kind_o),
    .x_position_o  (xo),
    .y_position_o  (yo),
    .feedrate_o    (feedrate_o)
  );

  assign x_position_o = signed'(xo);
  assign y_position_o = signed'(yo);

endmodule

/* src/mclp_front.sv */
module mclp_front (
  input  logic              in_valid_i,
  input  logic [7:0]        char_byte_i,
  input  logic              line_end_i,
  input  logic              full_i,
  output logic              in_stall_o,
  output logic              push_o,
  output mclp_pkg::entry_t  entry_o
);

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;

  always_comb begin
    entry_o.ch    = char_byte_i;
    entry_o.dval  = 4'(char_byte_i - 8'h30);
    entry_o.nul   = (char_byte_i == 8'h00);
    entry_o.delim = (char_byte_i == 8'h20) || (char_byte_i == 8'h09) ||
                    (char_byte_i == 8'h0D) || (char_byte_i == 8'h0A);
    entry_o.digit = (char_byte_i >= 8'h30) && (char_byte_i <= 8'h39);
    entry_o.last  = line_end_i;
  end

endmodule

/* src/mclp_queue.sv */
module mclp_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  mclp_pkg::entry_t  entry_i,
  input  logic              pop_i,
  output logic              full_o,
  output logic              valid_o,
  output mclp_pkg::entry_t  entry_o
);

  localparam int unsigned PW = $clog2(mclp_pkg::QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(mclp_pkg::QUEUE_DEPTH + 1);

  mclp_pkg::entry_t mem_q [mclp_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;

  assign full_o  = (cnt_q == CW'(mclp_pkg::QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign entry_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= PW'((32'(wr_q) + 1) % mclp_pkg::QUEUE_DEPTH);
      if (pop_i)  rd_q <= PW'((32'(rd_q) + 1) % mclp_pkg::QUEUE_DEPTH);
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (!push_i && pop_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= entry_i;
  end

endmodule

/* src/mclp_back.sv */
module mclp_back #(
  parameter int unsigned LINE_BUFFER_BYTES = 96
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  mclp_pkg::entry_t  q_entry_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [2:0]        parse_status_o,
  output logic [2:0]        command_kind_o,
  output logic [31:0]       x_position_o,
  output logic [31:0]       y_position_o,
  output logic [31:0]       feedrate_o
);

  localparam int unsigned BW = $clog2(LINE_BUFFER_BYTES + 1);

  logic [BW-1:0] bc_q, bc_d;
  logic          nb_q, nb_d, tok_q, tok_d, neg_q, neg_d, sgn_q, sgn_d;
  logic          ovf_q, ovf_d, err_q, err_d, nul_q, nul_d;
  logic [6:0]    ti_q, ti_d, dc_q, dc_d;
  logic [5:0]    km_q, km_d;
  logic [2:0]    kf_q, kf_d, seen_q, seen_d;
  logic [1:0]    arg_q, arg_d;
  logic [22:0]   dv_q, dv_d;
  logic [31:0]   xs_q, xs_d, ys_q, ys_d, fs_q, fs_d;

  logic          out_valid_q;
  logic [2:0]    st_q, kd_q;
  logic [31:0]   xo_q, yo_q, fo_q;
  logic [2:0]    st_c, kd_c;
  logic [31:0]   xo_c, yo_c, fo_c;

  logic          take;

  assign take  = q_valid_i && (!q_entry_i.last || !out_valid_q || !out_stall_i);
  assign pop_o = take;

  always_comb begin
    logic [7:0]  c;
    logic        do_close;
    logic [26:0] wide;
    logic [31:0] mag;
    c = q_entry_i.ch;
    bc_d = bc_q; nb_d = nb_q; tok_d = tok_q; neg_d = neg_q; sgn_d = sgn_q;
    ovf_d = ovf_q; err_d = err_q; nul_d = nul_q; ti_d = ti_q; dc_d = dc_q;
    km_d = km_q; kf_d = kf_q; seen_d = seen_q; arg_d = arg_q; dv_d = dv_q;
    xs_d = xs_q; ys_d = ys_q; fs_d = fs_q;
    st_c = mclp_pkg::ST_OK; kd_c = mclp_pkg::KIND_NONE;
    xo_c = '0; yo_c = '0; fo_c = '0;
    do_close = 1'b0;
    wide = '0;
    mag = '0;
    if (take) begin
      if (q_entry_i.nul) nul_d = 1'b1;
      if (!nul_d) begin
        if (bc_d < BW'(LINE_BUFFER_BYTES)) bc_d = bc_d + 1'b1;
        if (q_entry_i.delim) begin
          do_close = tok_d;
          tok_d    = 1'b0;
        end else begin
          nb_d = 1'b1;
          if (!tok_d) begin
            tok_d = 1'b1;
            ti_d  = '0;
            if (kf_d == mclp_pkg::KIND_NONE) begin
              km_d = '1;
            end else if (kf_d == mclp_pkg::KIND_MOVE) begin
              arg_d = mclp_pkg::ARG_X; neg_d = 1'b0; sgn_d = 1'b0;
              dc_d = '0; dv_d = '0; ovf_d = 1'b0;
            end else if (kf_d != mclp_pkg::KIND_UNKNOWN) begin
              err_d = 1'b1;
            end
          end
          if (kf_d == mclp_pkg::KIND_NONE) begin
            for (int k = 0; k < mclp_pkg::NUM_KW; k++) begin
              if (ti_d >= 7'(mclp_pkg::kw_len(3'(k)))) km_d[k] = 1'b0;
              else if (mclp_pkg::kw_char(3'(k), ti_d[3:0]) != c) km_d[k] = 1'b0;
            end
          end else if (kf_d == mclp_pkg::KIND_MOVE && !err_d) begin
            if (ti_d == 7'd0) begin
              if (c == "X")      arg_d = mclp_pkg::ARG_X;
              else if (c == "Y") arg_d = mclp_pkg::ARG_Y;
              else if (c == "F") arg_d = mclp_pkg::ARG_F;
              else               err_d = 1'b1;
            end else if (ti_d == 7'd1) begin
              if (c != "=" || seen_d[arg_d]) err_d = 1'b1;
            end else if ((c == 8'h0B || c == 8'h0C) && !sgn_d && dc_d == '0) begin
              sgn_d = sgn_d;
            end else if ((c == "+" || c == "-") && !sgn_d && dc_d == '0) begin
              sgn_d = 1'b1;
              neg_d = (c == "-");
            end else if (q_entry_i.digit) begin
              if (dc_d < mclp_pkg::TOKEN_MAX) dc_d = dc_d + 1'b1;
              if (!ovf_d) begin
                wide = 27'(dv_d) * 27'd10 + 27'(q_entry_i.dval);
                if (wide > 27'(mclp_pkg::FEED_LIMIT)) begin
                  ovf_d = 1'b1;
                  dv_d  = mclp_pkg::FEED_LIMIT + 1'b1;
                end else begin
                  dv_d = wide[22:0];
                end
              end
            end else begin
              err_d = 1'b1;
            end
          end
          if (ti_d < mclp_pkg::TOKEN_MAX) ti_d = ti_d + 1'b1;
        end
      end
      if (q_entry_i.last && tok_d) begin
        do_close = 1'b1;
        tok_d    = 1'b0;
      end
      if (do_close) begin
        if (kf_d == mclp_pkg::KIND_NONE) begin
          kf_d = mclp_pkg::KIND_UNKNOWN;
          for (int k = 0; k < mclp_pkg::NUM_KW; k++) begin
            if (km_d[k] && ti_d == 7'(mclp_pkg::kw_len(3'(k)))) kf_d = mclp_pkg::kw_kind(3'(k));
          end
        end else if (kf_d == mclp_pkg::KIND_MOVE && !err_d) begin
          mag = 32'(33'(dv_d) * 33'(mclp_pkg::MM_SCALE));
          if (ti_d < 7'd2 || dc_d == '0 || ovf_d) begin
            err_d = 1'b1;
          end else if (arg_d == mclp_pkg::ARG_F) begin
            if (neg_d || dv_d == '0) err_d = 1'b1;
            else begin
              fs_d = mag;
              seen_d[2] = 1'b1;
            end
          end else if (dv_d > mclp_pkg::POS_LIMIT) begin
            err_d = 1'b1;
          end else begin
            if (neg_d) mag = 32'd0 - mag;
            if (arg_d == mclp_pkg::ARG_X) xs_d = mag;
            else ys_d = mag;
            seen_d[arg_d] = 1'b1;
          end
        end
      end
      if (q_entry_i.last) begin
        if (!nb_d) st_c = mclp_pkg::ST_EMPTY;
        else if (bc_d >= BW'(LINE_BUFFER_BYTES)) st_c = mclp_pkg::ST_INVALID;
        else if (kf_d == mclp_pkg::KIND_UNKNOWN || kf_d == mclp_pkg::KIND_NONE)
          st_c = mclp_pkg::ST_UNKNOWN;
        else if (err_d) st_c = mclp_pkg::ST_INVALID;
        else if (kf_d == mclp_pkg::KIND_MOVE && seen_d != 3'b111) st_c = mclp_pkg::ST_MISSING;
        else begin
          kd_c = kf_d;
          if (kf_d == mclp_pkg::KIND_MOVE) begin
            xo_c = xs_d; yo_c = ys_d; fo_c = fs_d;
          end
        end
        bc_d = '0; nb_d = 1'b0; tok_d = 1'b0; neg_d = 1'b0; sgn_d = 1'b0;
        ovf_d = 1'b0; err_d = 1'b0; nul_d = 1'b0; ti_d = '0; dc_d = '0;
        km_d = '1; kf_d = mclp_pkg::KIND_NONE; seen_d = '0; arg_d = mclp_pkg::ARG_X;
        dv_d = '0; xs_d = '0; ys_d = '0; fs_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bc_q <= '0; nb_q <= 1'b0; tok_q <= 1'b0; neg_q <= 1'b0; sgn_q <= 1'b0;
      ovf_q <= 1'b0; err_q <= 1'b0; nul_q <= 1'b0; ti_q <= '0; dc_q <= '0;
      km_q <= '1; kf_q <= mclp_pkg::KIND_NONE; seen_q <= '0; arg_q <= mclp_pkg::ARG_X;
      dv_q <= '0; xs_q <= '0; ys_q <= '0; fs_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      bc_q <= bc_d; nb_q <= nb_d; tok_q <= tok_d; neg_q <= neg_d; sgn_q <= sgn_d;
      ovf_q <= ovf_d; err_q <= err_d; nul_q <= nul_d; ti_q <= ti_d; dc_q <= dc_d;
      km_q <= km_d; kf_q <= kf_d; seen_q <= seen_d; arg_q <= arg_d;
      dv_q <= dv_d; xs_q <= xs_d; ys_q <= ys_d; fs_q <= fs_d;
      if (take && q_entry_i.last) out_valid_q <= 1'b1;
      else if (!out_stall_i)      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && q_entry_i.last) begin
      st_q <= st_c; kd_q <= kd_c; xo_q <= xo_c; yo_q <= yo_c; fo_q <= fo_c;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign parse_status_o = st_q;
  assign command_kind_o = kd_q;
  assign x_position_o   = xo_q;
  assign y_position_o   = yo_q;
  assign feedrate_o     = fo_q;

endmodule

/* src/mclp_checker.sv */
module mclp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  parse_status_o,
  input logic [2:0]  command_kind_o,
  input logic [31:0] x_position_o,
  input logic [31:0] y_position_o,
  input logic [31:0] feedrate_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(parse_status_o) &&
    $stable(command_kind_o) && $stable(x_position_o))
    else $error("stalled result changed");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && parse_status_o != mclp_pkg::ST_OK |->
    command_kind_o == mclp_pkg::KIND_NONE && x_position_o == '0 &&
    y_position_o == '0 && feedrate_o == '0)
    else $error("error result carries data");

  a_ok_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && parse_status_o == mclp_pkg::ST_OK |->
    command_kind_o != mclp_pkg::KIND_NONE && command_kind_o != mclp_pkg::KIND_UNKNOWN)
    else $error("ok result without command");

  a_move_feed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && parse_status_o == mclp_pkg::ST_OK &&
    command_kind_o == mclp_pkg::KIND_MOVE |-> feedrate_o != '0)
    else $error("move with zero feedrate");

  a_other_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && command_kind_o != mclp_pkg::KIND_MOVE |->
    x_position_o == '0 && y_position_o == '0 && feedrate_o == '0)
    else $error("non-move result carries data");

endmodule

bind motion_command_line_parser mclp_checker u_mclp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .parse_status_o(parse_status_o),
  .command_kind_o(command_kind_o),
  .x_position_o  (x_position_o),
  .y_position_o  (y_position_o),
  .feedrate_o    (feedrate_o)
);

/* tb/sv/motion_command_line_parser_test.sv */
module motion_command_line_parser_test;

  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  kind;
    logic [31:0] xpos;
    logic [31:0] ypos;
    logic [31:0] feed;
  } line_result_t;

  typedef logic [7:0] bytes_t[$];

  typedef struct {
    bytes_t       text;
    bit           typed;
    line_result_t res;
  } line_row_t;

  localparam int unsigned LINE_BYTES = 96;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic [7:0] char_byte_i = 8'h00;
  logic line_end_i = 1'b0;
  logic out_stall_i = 1'b0;
  logic in_stall_o, out_valid_o;
  logic [2:0] parse_status_o, command_kind_o;
  logic signed [31:0] x_position_o, y_position_o;
  logic [31:0] feedrate_o;

  motion_command_line_parser uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .char_byte_i(char_byte_i), .line_end_i(line_end_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .parse_status_o(parse_status_o), .command_kind_o(command_kind_o),
    .x_position_o(x_position_o), .y_position_o(y_position_o),
    .feedrate_o(feedrate_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #4000000;
    $display("CHECKS FAILED");
    $finish;
  end

  // parser shadow state
  int unsigned n_bytes, tok_pos, n_digits, mag, arg_sel, seen, err;
  bit nonblank, open_tok, neg, sgn, ovf, nul;
  logic [5:0] kw_live;
  int unsigned found;
  logic [31:0] xs, ys, fs;

  line_result_t expected_q[$];
  int errors = 0;
  bit calm = 1'b0;

  string kw_names[6] = '{"PING", "STATUS", "MOVE", "STOP", "ESTOP", ""};
  int unsigned kw_codes[6] = '{mclp_pkg::KIND_PING, mclp_pkg::KIND_STATUS,
                               mclp_pkg::KIND_MOVE, mclp_pkg::KIND_STOP,
                               mclp_pkg::KIND_ESTOP, mclp_pkg::KIND_FLT_CLR};

  function automatic void line_reset();
    n_bytes = 0; nonblank = 0; tok_pos = 0; open_tok = 0; kw_live = '1;
    found = mclp_pkg::KIND_NONE; arg_sel = 0; neg = 0; sgn = 0; n_digits = 0; mag = 0;
    ovf = 0; seen = 0; err = 0; xs = 0; ys = 0; fs = 0; nul = 0;
  endfunction

  function automatic void mark_bad();
    if (err == 0) err = mclp_pkg::ST_INVALID;
  endfunction

  function automatic void tok_start();
    tok_pos = 0;
    if (found == mclp_pkg::KIND_NONE) kw_live = '1;
    else if (found == mclp_pkg::KIND_MOVE) begin
      arg_sel = 0; neg = 0; sgn = 0; n_digits = 0; mag = 0; ovf = 0;
    end else if (found != mclp_pkg::KIND_UNKNOWN) mark_bad();
  endfunction

  function automatic void tok_byte(logic [7:0] c);
    if (found == mclp_pkg::KIND_NONE) begin
      for (int k = 0; k < 6; k++)
        if (tok_pos >= kw_names[k].len() || kw_names[k][tok_pos] != c) kw_live[k] = 1'b0;
    end else if (found == mclp_pkg::KIND_MOVE && err == 0) begin
      if (tok_pos == 0) begin
        if (c == "X") arg_sel = mclp_pkg::ARG_X;
        else if (c == "Y") arg_sel = mclp_pkg::ARG_Y;
        else if (c == "F") arg_sel = mclp_pkg::ARG_F;
        else mark_bad();
      end else if (tok_pos == 1) begin
        if (c != "=" || seen[arg_sel]) mark_bad();
      end else if ((c == 8'h0B || c == 8'h0C) && !sgn && n_digits == 0) begin
      end else if ((c == "+" || c == "-") && !sgn && n_digits == 0) begin
        sgn = 1; neg = (c == "-");
      end else if (c >= "0" && c <= "9") begin
        if (n_digits < 127) n_digits++;
        if (!ovf) begin
          mag = mag * 10 + (c - "0");
          if (mag > 4294967) begin ovf = 1; mag = 4294968; end
        end
      end else mark_bad();
    end
    if (tok_pos < 127) tok_pos++;
  endfunction

  function automatic void tok_end();
    logic [31:0] v;
    if (found == mclp_pkg::KIND_NONE) begin
      found = mclp_pkg::KIND_UNKNOWN;
      for (int k = 0; k < 6; k++)
        if (kw_live[k] && tok_pos == kw_names[k].len()) found = kw_codes[k];
      return;
    end
    if (found != mclp_pkg::KIND_MOVE || err != 0) return;
    if (tok_pos < 2 || n_digits == 0 || ovf) begin mark_bad(); return; end
    if (arg_sel == mclp_pkg::ARG_F) begin
      if (neg || mag == 0) begin mark_bad(); return; end
      fs = mag * 1000;
    end else begin
      if (mag > 2147483) begin mark_bad(); return; end
      v = mag * 1000;
      if (neg) v = -v;
      if (arg_sel == mclp_pkg::ARG_X) xs = v; else ys = v;
    end
    seen[arg_sel] = 1'b1;
  endfunction

  function automatic bit parse_byte(logic [7:0] c, bit last, output line_result_t r);
    r = '0;
    if (c == 0) nul = 1;
    if (!nul) begin
      if (n_bytes < LINE_BYTES) n_bytes++;
      if (c == " " || c == 8'h09 || c == 8'h0D || c == 8'h0A) begin
        if (open_tok) tok_end();
        open_tok = 0;
      end else begin
        nonblank = 1;
        if (!open_tok) begin tok_start(); open_tok = 1; end
        tok_byte(c);
      end
    end
    if (!last) return 0;
    if (open_tok) begin tok_end(); open_tok = 0; end
    if (!nonblank) r.status = mclp_pkg::ST_EMPTY;
    else if (n_bytes >= LINE_BYTES) r.status = mclp_pkg::ST_INVALID;
    else if (found == mclp_pkg::KIND_UNKNOWN || found == mclp_pkg::KIND_NONE)
      r.status = mclp_pkg::ST_UNKNOWN;
    else if (err != 0) r.status = 3'(err);
    else if (found == mclp_pkg::KIND_MOVE && seen != 7) r.status = mclp_pkg::ST_MISSING;
    else begin
      r.kind = 3'(found);
      if (found == mclp_pkg::KIND_MOVE) begin r.xpos = xs; r.ypos = ys; r.feed = fs; end
    end
    line_reset();
    return 1;
  endfunction

  task automatic send_byte(logic [7:0] c, bit last, bit typed, line_result_t want);
    line_result_t r;
    if (!calm && $urandom_range(0, 9) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    char_byte_i <= c;
    line_end_i <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (parse_byte(c, last, r)) begin
      if (typed && r !== want)
        $display("%0t table row disagrees with predictor: exp %p got %p", $time, want, r);
      expected_q.push_back(typed ? want : r);
    end
  endtask

  task automatic send_line(bytes_t s, bit typed, line_result_t want);
    for (int i = 0; i < s.size(); i++) send_byte(s[i], i == s.size() - 1, typed, want);
  endtask

  function automatic bytes_t to_bytes(string s);
    bytes_t b;
    for (int i = 0; i < s.len(); i++) b.push_back(s[i]);
    return b;
  endfunction

  function automatic void push_text(ref bytes_t b, input string s);
    for (int i = 0; i < s.len(); i++) b.push_back(s[i]);
  endfunction

  function automatic string rand_num(bit signed_ok);
    string s;
    int nd;
    s = "";
    if ($urandom_range(0, 7) == 0) begin
      s = " ";
      s.putc(0, 8'h0B);
    end
    if (signed_ok && $urandom_range(0, 2) == 0) begin
      if ($urandom_range(0, 1) == 1) s = {s, "-"};
      else s = {s, "+"};
    end
    nd = $urandom_range(0, 9) == 0 ? $urandom_range(7, 12) : $urandom_range(1, 7);
    for (int i = 0; i < nd; i++) begin
      s = {s, "0"};
      s.putc(s.len() - 1, 8'(8'h30 + $urandom_range(0, 9)));
    end
    return s;
  endfunction

  function automatic bytes_t rand_line();
    string s, a[$], seps = " \t\r\n";
    bytes_t b;
    int m = $urandom_range(0, 99);
    s = "";
    if (m < 55) begin
      a.push_back({"X=", rand_num(1)});
      a.push_back({"Y=", rand_num(1)});
      a.push_back({"F=", rand_num($urandom_range(0, 9) == 0)});
      a.shuffle();
      if ($urandom_range(0, 5) == 0) void'(a.pop_back());
      if ($urandom_range(0, 7) == 0) a.push_back({"X=", rand_num(1)});
      s = "MOVE";
      foreach (a[i]) s = {s, " ", a[i]};
    end else if (m < 75) s = kw_names[$urandom_range(0, 5)];
    else if (m < 85) begin
      s = kw_names[$urandom_range(0, 5)];
      s[$urandom_range(0, s.len() - 1)] = 8'($urandom_range(1, 255));
    end
    b = to_bytes(s);
    if (m >= 85)
      repeat ($urandom_range(1, 20)) b.push_back(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 4) == 0) b.push_front(seps[$urandom_range(0, 3)]);
    if ($urandom_range(0, 3) == 0) b.push_back(seps[$urandom_range(0, 3)]);
    if ($urandom_range(0, 20) == 0)
      repeat ($urandom_range(70, 100)) b.push_back(" ");
    return b;
  endfunction

  line_row_t dir_rows[$];

  function automatic void add_row(bytes_t t, bit typed, line_result_t r);
    line_row_t row;
    row.text = t; row.typed = typed; row.res = r;
    dir_rows.push_back(row);
  endfunction

  function automatic line_result_t mk(logic [2:0] st, logic [2:0] kd,
                                      logic [31:0] x, logic [31:0] y, logic [31:0] f);
    line_result_t r;
    r.status = st; r.kind = kd; r.xpos = x; r.ypos = y; r.feed = f;
    return r;
  endfunction

  initial begin
    string pad, cf;
    bytes_t t, s;
    line_result_t z;
    z = '0;
    pad = "";
    cf = "CLEAR_";
    kw_names[5] = {cf, "FAULT"};
    line_reset();
    repeat (91) pad = {pad, " "};
    add_row(to_bytes("PING"), 1, mk(mclp_pkg::ST_OK, mclp_pkg::KIND_PING, 0, 0, 0));
    add_row(to_bytes("STATUS"), 1, mk(mclp_pkg::ST_OK, mclp_pkg::KIND_STATUS, 0, 0, 0));
    add_row(to_bytes("STOP"), 1, mk(mclp_pkg::ST_OK, mclp_pkg::KIND_STOP, 0, 0, 0));
    add_row(to_bytes("ESTOP\n"), 1, mk(mclp_pkg::ST_OK, mclp_pkg::KIND_ESTOP, 0, 0, 0));
    add_row(to_bytes(kw_names[5]), 1,
            mk(mclp_pkg::ST_OK, mclp_pkg::KIND_FLT_CLR, 0, 0, 0));
    add_row(to_bytes(" \t\r\n"), 1, mk(mclp_pkg::ST_EMPTY, mclp_pkg::KIND_NONE, 0, 0, 0));
    add_row(to_bytes("PINGX"), 1, mk(mclp_pkg::ST_UNKNOWN, mclp_pkg::KIND_NONE, 0, 0, 0));
    add_row(to_bytes("PING X"), 1, mk(mclp_pkg::ST_INVALID, mclp_pkg::KIND_NONE, 0, 0, 0));
    add_row(to_bytes({"PING", pad, " "}), 1,
            mk(mclp_pkg::ST_INVALID, mclp_pkg::KIND_NONE, 0, 0, 0));
    add_row(to_bytes("MOVE X=1 Y=2"), 1,
            mk(mclp_pkg::ST_MISSING, mclp_pkg::KIND_NONE, 0, 0, 0));
    add_row(to_bytes("MOVE X=2147483 Y=-2147483 F=4294967"), 1,
            mk(mclp_pkg::ST_OK, mclp_pkg::KIND_MOVE, 32'd2147483000, -32'sd2147483000,
               32'd4294967000));
    add_row(to_bytes("MOVE X=2147484 Y=0 F=1"), 1,
            mk(mclp_pkg::ST_INVALID, mclp_pkg::KIND_NONE, 0, 0, 0));
    add_row(to_bytes("MOVE X=0 Y=0 F=0"), 1,
            mk(mclp_pkg::ST_INVALID, mclp_pkg::KIND_NONE, 0, 0, 0));
    add_row(to_bytes("MOVE X=0 Y=0 F=-5"), 1,
            mk(mclp_pkg::ST_INVALID, mclp_pkg::KIND_NONE, 0, 0, 0));
    add_row(to_bytes("MOVE X=1 X=2 Y=0 F=1"), 1,
            mk(mclp_pkg::ST_INVALID, mclp_pkg::KIND_NONE, 0, 0, 0));
    add_row(to_bytes("MOVE X=99999999999 Y=0 F=1"), 1,
            mk(mclp_pkg::ST_INVALID, mclp_pkg::KIND_NONE, 0, 0, 0));
    t = to_bytes("MOVE X=");
    t.push_back(8'h0B);
    t.push_back(8'h0C);
    push_text(t, "+007 Y=-0 F=0012");
    add_row(t, 1, mk(mclp_pkg::ST_OK, mclp_pkg::KIND_MOVE, 7000, 0, 12000));
    add_row(to_bytes("MOVE X= Y=1 F=1"), 1,
            mk(mclp_pkg::ST_INVALID, mclp_pkg::KIND_NONE, 0, 0, 0));
    add_row(to_bytes("MOVE X=1a Y=1 F=1"), 1,
            mk(mclp_pkg::ST_INVALID, mclp_pkg::KIND_NONE, 0, 0, 0));
    t = to_bytes("STOP");
    t.push_back(8'h00);
    push_text(t, "junk");
    add_row(t, 1, mk(mclp_pkg::ST_OK, mclp_pkg::KIND_STOP, 0, 0, 0));
    t = to_bytes("MOVE F=3 Y=-1 X=5");
    t.push_back(8'hFF);
    add_row(t, 0, z);
    add_row(to_bytes("MOVE Z=1"), 0, z);
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_rows[i]) send_line(dir_rows[i].text, dir_rows[i].typed, dir_rows[i].res);
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    for (int n = 0; n < 1330;) begin
      s = rand_line();
      if (s.size() == 0) continue;
      if (n > 1150) calm = 1'b1;
      send_line(s, 0, z);
      n += s.size();
    end
    in_valid_i <= 1'b0;
    for (int w = 0; w < 100000 && expected_q.size() != 0; w++) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0 && expected_q.size() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    @(posedge rst_ni);
    forever begin
      if (!calm && $urandom_range(0, 9) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    line_result_t got, want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {parse_status_o, command_kind_o, x_position_o, y_position_o, feedrate_o};
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t unexpected result %p", $time, got);
      end else begin
        want = expected_q.pop_front();
        if (got.status !== want.status) begin
          errors++; $display("%0t status exp %0d got %0d", $time, want.status, got.status);
        end
        if (got.kind !== want.kind) begin
          errors++; $display("%0t kind exp %0d got %0d", $time, want.kind, got.kind);
        end
        if (got.xpos !== want.xpos) begin
          errors++; $display("%0t x exp %0d got %0d", $time, $signed(want.xpos),
                             $signed(got.xpos));
        end
        if (got.ypos !== want.ypos) begin
          errors++; $display("%0t y exp %0d got %0d", $time, $signed(want.ypos),
                             $signed(got.ypos));
        end
        if (got.feed !== want.feed) begin
          errors++; $display("%0t feed exp %0d got %0d", $time, want.feed, got.feed);
        end
      end
    end
  end

endmodule
